// ===== sv/limit_order_book_matcher_macros.svh =====
// assertion macros shared by the order book matcher rtl
// expects clk and rst_n in the scope of each use
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LOBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lobm_pkg.sv =====
// shared types, constants and the modulo helper of the order book matcher
// no dependencies; used by lobm_cell, lobm_book and limit_order_book_matcher
package lobm_pkg;

  localparam int PRICE_W = 32;
  localparam int AMT_W   = 32;
  localparam int MOD_W   = 30;

  localparam logic [31:0] MOD_P   = 32'd1000000007;
  localparam logic [31:0] MOD_P2  = 32'd2000000014;
  localparam logic [31:0] MOD_P3  = 32'd3000000021;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DEL,
    ST_REINS,
    ST_REST,
    ST_FINISH
  } lobm_state_t;

  // book level commands
  typedef enum logic [2:0] {
    BOP_NOP,
    BOP_TRIM,
    BOP_POP,
    BOP_DEL,
    BOP_REINS,
    BOP_PUSH
  } book_op_t;

  // per cell actions, broadcast along the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TRIM,
    CELL_SHIFT,
    CELL_DROP,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    book_op_t             op;
    logic [PRICE_W-1:0]   price;
    logic [AMT_W-1:0]     amount;
  } book_cmd_t;

  typedef struct packed {
    logic                 head_valid;
    logic                 head_last;
    logic                 room;
    logic [PRICE_W-1:0]   head_price;
    logic [AMT_W-1:0]     head_amount;
  } book_stat_t;

  // x mod p for a 32 bit x: the top two bits give the quotient to within one
  function automatic logic [MOD_W-1:0] mod_reduce(input logic [31:0] x);
    logic [31:0] mult;
    logic [31:0] r;
    unique case (x[31:30])
      2'd0:    mult = 32'd0;
      2'd1:    mult = MOD_P;
      2'd2:    mult = MOD_P2;
      default: mult = MOD_P3;
    endcase
    r = x - mult;
    if (r >= MOD_P) begin
      r = r - MOD_P;
    end
    return r[MOD_W-1:0];
  endfunction

endpackage

// ===== sv/limit_order_book_matcher.sv =====
// Limit order book matcher. One order per input beat (price, amount, side); one result beat per
// order with the resting total mod 1000000007 and a flag for a remainder dropped on a full book.
// Each side is a chain of BOOK_DEPTH cells kept in best-first order, so the best entry is always
// the head cell. An order passes match, rest and finish when it trades nothing or only trims the
// head, plus a match step per resting entry it consumes when that entry was the last stored, else
// match, delete and reinsert steps (pop the head, drop and reinsert the entry that takes over
// its storage slot). The next order is taken once the previous result is registered; the result
// beat then waits in its own register. Depends on lobm_pkg, lobm_book, lobm_cell and the macros.
module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] price, [63:32] amount
  input  logic        in_tuser,   // [0] side: 0 buy, 1 sell
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [29:0] backlog_mod, [30] book_full, [31] zero
);
  import lobm_pkg::*;

  localparam int CNTW = $clog2(BOOK_DEPTH + 1);

  lobm_state_t        state_r, state_nxt;
  logic [PRICE_W-1:0] price_r;
  logic [AMT_W-1:0]   amount_r;
  logic [AMT_W-1:0]   rem_r;
  logic               side_r;
  logic               full_r;
  logic               rested_r;
  logic [MOD_W-1:0]   rem_red_r;
  logic [MOD_W-1:0]   amt_red_r;
  logic [MOD_W-1:0]   mod_r, mod_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [MOD_W-1:0]   out_mod_r;
  logic               out_full_r;

  book_cmd_t          buy_cmd, sell_cmd, opp_cmd, own_cmd;
  book_stat_t         buy_st, sell_st, opp_st, own_st;
  logic [CNTW-1:0]    buy_cnt, sell_cnt;

  logic               in_beat;
  logic               crosses;
  logic               trade;
  logic               partial;
  logic               rest_ok;
  logic               out_load;
  logic [32:0]        sum;

  lobm_book #(
    .DEPTH (BOOK_DEPTH)
  ) u_buy (
    .clk     (clk),
    .rst_n   (rst_n),
    .descend (1'b1),
    .cmd     (buy_cmd),
    .stat    (buy_st),
    .count   (buy_cnt)
  );

  lobm_book #(
    .DEPTH (BOOK_DEPTH)
  ) u_sell (
    .clk     (clk),
    .rst_n   (rst_n),
    .descend (1'b0),
    .cmd     (sell_cmd),
    .stat    (sell_st),
    .count   (sell_cnt)
  );

  assign opp_st   = side_r ? buy_st : sell_st;
  assign own_st   = side_r ? sell_st : buy_st;
  assign buy_cmd  = side_r ? opp_cmd : own_cmd;
  assign sell_cmd = side_r ? own_cmd : opp_cmd;

  assign in_beat  = in_tvalid && in_tready;
  assign crosses  = side_r ? (opp_st.head_price >= price_r) : (opp_st.head_price <= price_r);
  assign trade    = (rem_r != '0) && opp_st.head_valid && crosses;
  assign partial  = (rem_r < opp_st.head_amount);
  assign rest_ok  = (rem_r != '0) && own_st.room;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (!trade || partial) begin
          state_nxt = ST_REST;
        end else if (!opp_st.head_last) begin
          state_nxt = ST_DEL;
        end
      end
      ST_DEL:   state_nxt = ST_REINS;
      ST_REINS: state_nxt = ST_MATCH;
      ST_REST:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready      = 1'b0;
    out_load       = 1'b0;
    opp_cmd.op     = BOP_NOP;
    opp_cmd.price  = price_r;
    opp_cmd.amount = rem_r;
    own_cmd.op     = BOP_NOP;
    own_cmd.price  = price_r;
    own_cmd.amount = rem_r;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_MATCH: begin
        if (trade) begin
          opp_cmd.op = partial ? BOP_TRIM : BOP_POP;
        end
      end
      ST_DEL:   opp_cmd.op = BOP_DEL;
      ST_REINS: opp_cmd.op = BOP_REINS;
      ST_REST: begin
        if (rest_ok) begin
          own_cmd.op = BOP_PUSH;
        end
      end
      ST_FINISH: out_load = !out_tvalid_r || out_tready;
      default: begin
      end
    endcase
  end

  // backlog update: total - amount + remainder (+ remainder again when it rests)
  always_comb begin
    sum = {3'b000, mod_r} + {3'b000, rem_red_r}
        + {3'b000, (rested_r ? rem_red_r : {MOD_W{1'b0}})}
        - {3'b000, amt_red_r};
    priority if (sum[32]) begin
      sum = sum + {1'b0, MOD_P};
    end else if (sum >= {1'b0, MOD_P2}) begin
      sum = sum - {1'b0, MOD_P2};
    end else if (sum >= {1'b0, MOD_P}) begin
      sum = sum - {1'b0, MOD_P};
    end
    mod_nxt = out_load ? sum[MOD_W-1:0] : mod_r;
  end

  assign out_tvalid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      mod_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      mod_r        <= mod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_red_r <= mod_reduce(amount_r);
    if (in_beat) begin
      price_r  <= in_tdata[31:0];
      amount_r <= in_tdata[63:32];
      rem_r    <= in_tdata[63:32];
      side_r   <= in_tuser;
    end
    if (state_r == ST_MATCH && trade) begin
      rem_r <= partial ? '0 : (rem_r - opp_st.head_amount);
    end
    if (state_r == ST_REST) begin
      rested_r  <= rest_ok;
      full_r    <= (rem_r != '0) && !own_st.room;
      rem_red_r <= mod_reduce(rem_r);
    end
    if (out_load) begin
      out_mod_r  <= sum[MOD_W-1:0];
      out_full_r <= full_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_full_r, out_mod_r};

`include "limit_order_book_matcher_macros.svh"

  `LOBM_ASSERT_SAME(a_book_bound, 1'b1, (buy_cnt <= CNTW'(BOOK_DEPTH)) && (sell_cnt <= CNTW'(BOOK_DEPTH)), "book occupancy beyond depth")
  `LOBM_ASSERT_SAME(a_full_flag, out_load && full_r, (side_r ? sell_cnt : buy_cnt) == CNTW'(BOOK_DEPTH), "remainder dropped on a book with room")
  `LOBM_ASSERT_NEXT(a_rem_shrinks, state_r != ST_IDLE, rem_r <= $past(rem_r), "open quantity grew while matching")

endmodule

// ===== sv/lobm_cell.sv =====
// one slot of a sorted book chain: price, amount and storage tag of one entry
// depends on lobm_pkg; instantiated in a row by lobm_book
module lobm_cell #(
  parameter int TAGW = 6
) (
  input  logic                      clk,
  input  lobm_pkg::cell_op_t        op,
  input  logic                      descend,
  input  logic                      is_head,
  input  logic                      valid,
  input  logic [lobm_pkg::PRICE_W-1:0] key_price,
  input  logic [lobm_pkg::AMT_W-1:0]   key_amount,
  input  logic [TAGW-1:0]           key_tag,
  input  logic                      left_ahead,
  input  logic [lobm_pkg::PRICE_W-1:0] left_price,
  input  logic [lobm_pkg::AMT_W-1:0]   left_amount,
  input  logic [TAGW-1:0]           left_tag,
  input  logic [lobm_pkg::PRICE_W-1:0] right_price,
  input  logic [lobm_pkg::AMT_W-1:0]   right_amount,
  input  logic [TAGW-1:0]           right_tag,
  output logic                      ahead,
  output logic [lobm_pkg::PRICE_W-1:0] price,
  output logic [lobm_pkg::AMT_W-1:0]   amount,
  output logic [TAGW-1:0]           tag
);
  import lobm_pkg::*;

  logic [PRICE_W-1:0] price_r, price_nxt;
  logic [AMT_W-1:0]   amount_r, amount_nxt;
  logic [TAGW-1:0]    tag_r, tag_nxt;
  logic               better;

  // ahead of the key: better price, or same price and lower storage tag
  assign better = descend ? (price_r > key_price) : (price_r < key_price);
  assign ahead  = valid && (better || ((price_r == key_price) && (tag_r < key_tag)));

  always_comb begin
    price_nxt  = price_r;
    amount_nxt = amount_r;
    tag_nxt    = tag_r;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_TRIM: begin
        if (is_head) begin
          amount_nxt = amount_r - key_amount;
        end
      end
      CELL_SHIFT: begin
        price_nxt  = right_price;
        amount_nxt = right_amount;
        tag_nxt    = right_tag;
      end
      CELL_DROP: begin
        if (!ahead) begin
          price_nxt  = right_price;
          amount_nxt = right_amount;
          tag_nxt    = right_tag;
        end
      end
      CELL_INSERT: begin
        if (!ahead) begin
          if (left_ahead) begin
            price_nxt  = key_price;
            amount_nxt = key_amount;
            tag_nxt    = key_tag;
          end else begin
            price_nxt  = left_price;
            amount_nxt = left_amount;
            tag_nxt    = left_tag;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    price_r  <= price_nxt;
    amount_r <= amount_nxt;
    tag_r    <= tag_nxt;
  end

  assign price  = price_r;
  assign amount = amount_r;
  assign tag    = tag_r;

endmodule

// ===== sv/lobm_book.sv =====
// one side of the order book: a chain of lobm_cell kept in best-first order
// depends on lobm_pkg and lobm_cell; two instances sit in the top level
module lobm_book #(
  parameter  int DEPTH = 64,
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW  = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  descend,
  input  lobm_pkg::book_cmd_t   cmd,
  output lobm_pkg::book_stat_t  stat,
  output logic [CNTW-1:0]       count
);
  import lobm_pkg::*;

  logic [CNTW-1:0]    count_r, count_nxt;
  logic [CNTW-1:0]    fill_r, fill_nxt;
  logic [PRICE_W-1:0] lp_r;
  logic [AMT_W-1:0]   la_r;
  logic [IDXW-1:0]    b_r;

  cell_op_t           cop;
  logic [PRICE_W-1:0] key_price;
  logic [AMT_W-1:0]   key_amount;
  logic [IDXW-1:0]    key_tag;
  logic [IDXW-1:0]    last_tag;
  logic [CNTW-1:0]    count_m1;

  logic [PRICE_W-1:0] c_price  [DEPTH];
  logic [AMT_W-1:0]   c_amount [DEPTH];
  logic [IDXW-1:0]    c_tag    [DEPTH];
  logic [DEPTH-1:0]   c_ahead;
  logic [DEPTH-1:0]   c_valid;

  logic [DEPTH-1:0]   lft_ahead;
  logic [PRICE_W-1:0] lft_price  [DEPTH];
  logic [AMT_W-1:0]   lft_amount [DEPTH];
  logic [IDXW-1:0]    lft_tag    [DEPTH];
  logic [PRICE_W-1:0] rgt_price  [DEPTH];
  logic [AMT_W-1:0]   rgt_amount [DEPTH];
  logic [IDXW-1:0]    rgt_tag    [DEPTH];

  logic [PRICE_W-1:0] cap_price;
  logic [AMT_W-1:0]   cap_amount;

  assign count_m1 = count_r - CNTW'(1);
  assign last_tag = count_m1[IDXW-1:0];

  // command to cell action and broadcast key
  always_comb begin
    cop        = CELL_HOLD;
    key_price  = cmd.price;
    key_amount = cmd.amount;
    key_tag    = count_r[IDXW-1:0];
    unique case (cmd.op)
      BOP_NOP:   cop = CELL_HOLD;
      BOP_TRIM:  cop = CELL_TRIM;
      BOP_POP:   cop = CELL_SHIFT;
      BOP_DEL: begin
        // the relabelled entry still carries the old last tag, now equal to count
        cop       = CELL_DROP;
        key_price = lp_r;
      end
      BOP_REINS: begin
        cop        = CELL_INSERT;
        key_price  = lp_r;
        key_amount = la_r;
        key_tag    = b_r;
      end
      BOP_PUSH:  cop = CELL_INSERT;
      default:   cop = CELL_HOLD;
    endcase
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_slot
    assign c_valid[j] = (CNTW'(j) < fill_r);

    if (j == 0) begin : g_first
      assign lft_ahead[j]  = 1'b1;
      assign lft_price[j]  = c_price[j];
      assign lft_amount[j] = c_amount[j];
      assign lft_tag[j]    = c_tag[j];
    end else begin : g_inner
      assign lft_ahead[j]  = c_ahead[j-1];
      assign lft_price[j]  = c_price[j-1];
      assign lft_amount[j] = c_amount[j-1];
      assign lft_tag[j]    = c_tag[j-1];
    end

    if (j == DEPTH - 1) begin : g_tail
      assign rgt_price[j]  = c_price[j];
      assign rgt_amount[j] = c_amount[j];
      assign rgt_tag[j]    = c_tag[j];
    end else begin : g_body
      assign rgt_price[j]  = c_price[j+1];
      assign rgt_amount[j] = c_amount[j+1];
      assign rgt_tag[j]    = c_tag[j+1];
    end

    lobm_cell #(
      .TAGW (IDXW)
    ) u_slot (
      .clk          (clk),
      .op           (cop),
      .descend      (descend),
      .is_head      (j == 0),
      .valid        (c_valid[j]),
      .key_price    (key_price),
      .key_amount   (key_amount),
      .key_tag      (key_tag),
      .left_ahead   (lft_ahead[j]),
      .left_price   (lft_price[j]),
      .left_amount  (lft_amount[j]),
      .left_tag     (lft_tag[j]),
      .right_price  (rgt_price[j]),
      .right_amount (rgt_amount[j]),
      .right_tag    (rgt_tag[j]),
      .ahead        (c_ahead[j]),
      .price        (c_price[j]),
      .amount       (c_amount[j]),
      .tag          (c_tag[j])
    );
  end

  // pick out the entry stored last, it takes over the freed storage slot
  always_comb begin
    cap_price  = '0;
    cap_amount = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (c_valid[j] && (c_tag[j] == last_tag)) begin
        cap_price  = cap_price | c_price[j];
        cap_amount = cap_amount | c_amount[j];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    fill_nxt  = fill_r;
    unique case (cmd.op)
      BOP_POP: begin
        count_nxt = count_r - CNTW'(1);
        fill_nxt  = fill_r - CNTW'(1);
      end
      BOP_DEL:   fill_nxt = fill_r - CNTW'(1);
      BOP_REINS: fill_nxt = fill_r + CNTW'(1);
      BOP_PUSH: begin
        count_nxt = count_r + CNTW'(1);
        fill_nxt  = fill_r + CNTW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fill_r  <= '0;
    end else begin
      count_r <= count_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == BOP_POP) begin
      lp_r <= cap_price;
      la_r <= cap_amount;
      b_r  <= c_tag[0];
    end
  end

  assign stat.head_valid  = (count_r != '0);
  assign stat.head_last   = (c_tag[0] == last_tag);
  assign stat.room        = (count_r < CNTW'(DEPTH));
  assign stat.head_price  = c_price[0];
  assign stat.head_amount = c_amount[0];
  assign count            = count_r;

endmodule
